[rtl/core/nnp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the numbered notation note parser.
// No dependencies.
package nnp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_PREFIXED = 7'b0000010,
    PH_DEGREE   = 7'b0000100,
    PH_APOS     = 7'b0001000,
    PH_SLASH    = 7'b0010000,
    PH_DUR      = 7'b0100000,
    PH_SKIP     = 7'b1000000
  } phase_e;

  // One finished note as it leaves the parser.
  typedef struct packed {
    logic [2:0]        degree;
    logic signed [1:0] octave;
    logic [2:0]        units;
    logic              dot;
    logic [6:0]        number;
  } note_t;

  // Everything one character produced: one or two notes.
  typedef struct packed {
    logic  two;
    note_t n0;
    note_t n1;
  } ev_t;

  localparam int unsigned QueueDepth = 4;

  localparam logic [9:0] ScaleHz [7] = '{
    10'd262, 10'd294, 10'd330, 10'd349, 10'd392, 10'd440, 10'd494
  };
  localparam logic [9:0] MinHz = 10'd40;

  // Table value, doubled for high and halved for low octave, floored at MinHz; degree 0 gives 0.
  function automatic logic [9:0] tone_of(input logic [2:0] degree,
                                         input logic signed [1:0] octave);
    logic [9:0] hz;
    hz = '0;
    if (degree != 3'd0) begin
      hz = ScaleHz[degree - 3'd1];
      if (octave > 2'sd0) begin
        hz = {hz[8:0], 1'b0};
      end else if (octave < 2'sd0) begin
        hz = {1'b0, hz[9:1]};
      end
      if (hz < MinHz) begin
        hz = MinHz;
      end
    end
    return hz;
  endfunction

endpackage

[rtl/core/numbered_notation_note_parser.sv]
`timescale 1ns / 1ps
// Top level of the numbered notation note parser: front, queue and back.
// Depends on nnp_pkg, nnp_front, nnp_queue and nnp_back.
//
//   channel  | handshake     | beat
//   ---------+---------------+-----------------------------------------------
//   input    | push / full   | text_char_i, end_of_text_i
//   result   | empty / pop   | note_degree_o .. tone_hz_o, note_number_o,
//            |               | run_last_o
//
// One character is taken per cycle while full is low; the front parses it in
// the cycle it is accepted and files one or two notes as a single record,
// or none. A note passes the queue and then the result register before it
// reaches the result ports; a two-note record leaves the back as two beats.
// The four-entry record queue decouples the sides: full rises only when the
// queue fills under a stalled pop or while two-note records drain.
// Reset (rst_ni low, asynchronous) clears the parser, note count, queue
// pointers and result valid flag; nothing needs a clearing pass.
module numbered_notation_note_parser import nnp_pkg::*; #(
  parameter int unsigned MAX_NOTES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        text_char_i,
  input  logic              end_of_text_i,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        note_degree_o,
  output logic signed [1:0] note_octave_o,
  output logic [2:0]        quarter_units_o,
  output logic              is_dotted_o,
  output logic [9:0]        tone_hz_o,
  output logic [6:0]        note_number_o,
  output logic              run_last_o
);

  logic accept;
  logic ev_valid;
  ev_t  ev;
  logic q_valid, q_pop;
  ev_t  q_data;

  // Take a character whenever the queue has room for its record.
  assign accept = push && !full;

  nnp_front #(
    .MAX_NOTES(MAX_NOTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_char_i  (text_char_i),
    .end_of_text_i(end_of_text_i),
    .ev_valid_o   (ev_valid),
    .ev_o         (ev)
  );

  // Hold records here while the result side stalls.
  nnp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (ev_valid),
    .data_i (ev),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  // Unpack records into result beats and compute the tone.
  nnp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .note_degree_o  (note_degree_o),
    .note_octave_o  (note_octave_o),
    .quarter_units_o(quarter_units_o),
    .is_dotted_o    (is_dotted_o),
    .tone_hz_o      (tone_hz_o),
    .note_number_o  (note_number_o),
    .run_last_o     (run_last_o)
  );

endmodule

[rtl/core/nnp_front.sv]
`timescale 1ns / 1ps
// Front part: per-character token parser and note counter.
// Depends on nnp_pkg.
module nnp_front import nnp_pkg::*; #(
  parameter int unsigned MAX_NOTES = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_char_i,
  input  logic       end_of_text_i,
  output logic       ev_valid_o,
  output ev_t        ev_o
);

  localparam int unsigned CntW = $clog2(MAX_NOTES + 1);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChFour  = 8'h34;
  localparam logic [7:0] ChSeven = 8'h37;

  typedef struct packed {
    phase_e            phase;
    logic [2:0]        degree;
    logic signed [1:0] octave;
    logic [2:0]        units;
    logic              dot;
  } held_t;

  localparam held_t HeldReset = '{phase: PH_IDLE, degree: 3'd0, octave: 2'sd0,
                                  units: 3'd4, dot: 1'b0};

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  endfunction

  function automatic logic is_degree(input logic [7:0] c);
    return ((c >= ChZero) && (c <= ChSeven)) || (c == ChDash);
  endfunction

  function automatic held_t start_note(input logic [7:0] c, input held_t h);
    held_t r;
    r = h;
    r.degree = ((c >= ChOne) && (c <= ChSeven)) ? c[2:0] : 3'd0;
    r.units  = 3'd4;
    r.dot    = 1'b0;
    r.phase  = PH_DEGREE;
    return r;
  endfunction

  function automatic held_t token_start(input logic [7:0] c, input held_t h);
    held_t r;
    r = h;
    if (is_space(c)) begin
      r.phase = PH_IDLE;
    end else if ((c == ChDot) || (c == 8'h4C) || (c == 8'h6C)) begin
      r.octave = -2'sd1;
      r.phase  = PH_PREFIXED;
    end else if ((c == 8'h48) || (c == 8'h68)) begin
      r.octave = 2'sd1;
      r.phase  = PH_PREFIXED;
    end else if ((c == 8'h4D) || (c == 8'h6D)) begin
      r.octave = 2'sd0;
      r.phase  = PH_PREFIXED;
    end else if (is_degree(c)) begin
      r.octave = 2'sd0;
      r = start_note(c, r);
    end else begin
      r.phase = PH_SKIP;
    end
    return r;
  endfunction

  function automatic note_t mk_note(input held_t h, input logic [CntW-1:0] n);
    note_t r;
    logic [CntW+6:0] n_ext;
    n_ext = {7'd0, n};
    r.degree = h.degree;
    r.octave = h.octave;
    r.units  = h.units;
    r.dot    = h.dot;
    r.number = n_ext[6:0];
    return r;
  endfunction

  held_t           held_q, h;
  logic [CntW-1:0] cnt_q, n;
  logic            va, vb, pend;
  note_t           ra, rb;

  always_comb begin
    h    = held_q;
    n    = cnt_q;
    va   = 1'b0;
    vb   = 1'b0;
    ra   = '0;
    rb   = '0;
    pend = 1'b0;
    if (text_char_i != 8'd0) begin
      case (held_q.phase)
        PH_PREFIXED: begin
          if (is_degree(text_char_i)) begin
            h = start_note(text_char_i, h);
          end else if (is_space(text_char_i)) begin
            h.phase = PH_IDLE;
          end else begin
            h.phase = PH_SKIP;
          end
        end
        PH_DEGREE, PH_APOS: begin
          if ((text_char_i == ChApos) && (held_q.phase == PH_DEGREE)) begin
            h.octave = 2'sd1;
            h.phase  = PH_APOS;
          end else if (text_char_i == ChSlash) begin
            h.phase = PH_SLASH;
          end else if (text_char_i == ChDot) begin
            h.units = h.units + (h.units >> 1);
            h.dot   = 1'b1;
            pend    = 1'b1;
          end else begin
            pend = 1'b1;
          end
        end
        PH_SLASH: begin
          if (text_char_i == ChTwo) begin
            h.units = 3'd2;
          end else if (text_char_i == ChFour) begin
            h.units = 3'd1;
          end else begin
            h.units = 3'd4;
          end
          h.phase = PH_DUR;
        end
        PH_DUR: begin
          if (text_char_i == ChDot) begin
            h.units = h.units + (h.units >> 1);
            h.dot   = 1'b1;
          end
          pend = 1'b1;
        end
        PH_SKIP: begin
          if (is_space(text_char_i)) begin
            h.phase = PH_IDLE;
          end
        end
        default: begin
          h = token_start(text_char_i, h);
        end
      endcase
      // Finish the held note, then restart on the character unless it was a dot.
      if (pend) begin
        if (n < CntW'(MAX_NOTES)) begin
          ra = mk_note(h, n);
          va = 1'b1;
          n  = n + 1'b1;
        end
        if (h.dot) begin
          h.phase = PH_IDLE;
        end else begin
          h = token_start(text_char_i, h);
        end
      end
    end
    // End of text or a NUL character: flush any note still open, then clear the parser.
    if ((text_char_i == 8'd0) || end_of_text_i) begin
      if ((h.phase == PH_DEGREE) || (h.phase == PH_APOS) ||
          (h.phase == PH_SLASH) || (h.phase == PH_DUR)) begin
        if (n < CntW'(MAX_NOTES)) begin
          if (va) begin
            rb = mk_note(h, n);
            vb = 1'b1;
          end else begin
            ra = mk_note(h, n);
            va = 1'b1;
          end
        end
      end
      h = HeldReset;
      n = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= HeldReset;
      cnt_q  <= '0;
    end else if (accept_i) begin
      held_q <= h;
      cnt_q  <= n;
    end
  end

  assign ev_valid_o = accept_i && va;
  assign ev_o.two   = va && vb;
  assign ev_o.n0    = ra;
  assign ev_o.n1    = rb;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_NOTES))
    else $error("note count passed its cap");
`endif

endmodule

[rtl/core/nnp_queue.sv]
`timescale 1ns / 1ps
// Short queue of per-character note records between front and back.
// Depends on nnp_pkg.
module nnp_queue import nnp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ev_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output ev_t  data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ev_t             mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign do_pop  = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("record pushed into a full queue");
`endif

endmodule

[rtl/core/nnp_back.sv]
`timescale 1ns / 1ps
// Back part: unpacks queued records, looks up the tone, holds the result beat.
// Depends on nnp_pkg.
module nnp_back import nnp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  ev_t               q_data_i,
  output logic              q_pop_o,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        note_degree_o,
  output logic signed [1:0] note_octave_o,
  output logic [2:0]        quarter_units_o,
  output logic              is_dotted_o,
  output logic [9:0]        tone_hz_o,
  output logic [6:0]        note_number_o,
  output logic              run_last_o
);

  logic  out_valid_q, sel_q;
  logic  load, last;
  note_t cur;

  assign load    = !out_valid_q || pop;
  assign cur     = sel_q ? q_data_i.n1 : q_data_i.n0;
  assign last    = !q_data_i.two || sel_q;
  assign q_pop_o = load && q_valid_i && last;
  assign empty   = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= q_valid_i;
      if (q_valid_i) begin
        sel_q <= !last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      note_degree_o   <= cur.degree;
      note_octave_o   <= cur.octave;
      quarter_units_o <= cur.units;
      is_dotted_o     <= cur.dot;
      tone_hz_o       <= tone_of(cur.degree, cur.octave);
      note_number_o   <= cur.number;
      run_last_o      <= last;
    end
  end

`ifndef ASSERT_OFF
  a_second_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !run_last_o) |-> q_valid_i)
    else $error("first of two notes shown but its record is gone");
  a_sel_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (q_valid_i && q_data_i.two))
    else $error("second-note select without a two-note record");
`endif

endmodule
